// ===== rtl/core/accel_limited_position_follower_macros.svh =====
// Assertion macros used by the follower's controller.
`ifndef ACCEL_LIMITED_POSITION_FOLLOWER_MACROS_SVH
`define ACCEL_LIMITED_POSITION_FOLLOWER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALPF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALPF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/alpf_pkg.sv =====
// Types and constants shared by the position follower modules.
package alpf_pkg;

	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int HALF_W     = 23;
	localparam int CENTER_W   = 24;
	localparam int LIMIT_W    = 31;
	localparam int TSTEP_W    = 21;
	localparam int BOUND_W    = 26;
	localparam int ERR_W      = 33;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 33;
	localparam int PROD_W     = 65;
	// Width of the largest product of a speed or acceleration magnitude with the time step.
	localparam int STEP_PROD_W = 52;

	localparam logic [TSTEP_W-1:0] TSTEP_RST = 21'd1048;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_HALF = 3'd0,
		REG_CENTER     = 3'd1,
		REG_VEL_LIMIT  = 3'd2,
		REG_ACC_LIMIT  = 3'd3,
		REG_TOLERANCE  = 3'd4,
		REG_TIME_STEP  = 3'd5,
		REG_START_POS  = 3'd6,
		REG_START_VEL  = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_DV  = 2'd0,
		MUL_V2  = 2'd1,
		MUL_BR  = 2'd2,
		MUL_DTH = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     prep;
		mul_sel_t mul_sel;
		logic     cap_dv;
		logic     cap_v2;
		logic     cmp;
		logic     vel;
		logic     fin;
	} cmd_t;

	typedef struct packed {
		logic short_path;
		logic out_free;
	} status_t;

	function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
		abs32 = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

endpackage

// ===== rtl/core/alpf_ifs.sv =====
// Valid/ready channel interfaces for target items and result items.
interface alpf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [alpf_pkg::DATA_W-1:0]  target_position;

	modport source (output valid, output target_position, input ready);
	modport sink (input valid, input target_position, output ready);
endinterface

interface alpf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [alpf_pkg::DATA_W-1:0]  position;
	logic signed [alpf_pkg::DATA_W-1:0]  velocity;
	logic                                clamped;
	logic                                settled;
	logic                                unstable;

	modport source (output valid, output position, output velocity, output clamped,
		output settled, output unstable, input ready);
	modport sink (input valid, input position, input velocity, input clamped,
		input settled, input unstable, output ready);
endinterface

// ===== rtl/core/alpf_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`include "accel_limited_position_follower_macros.svh"

module alpf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  alpf_pkg::status_t status,
	output alpf_pkg::cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PREP = 9'b000000010,
		S_MDV  = 9'b000000100,
		S_MV2  = 9'b000001000,
		S_MBR  = 9'b000010000,
		S_CMP  = 9'b000100000,
		S_VEL  = 9'b001000000,
		S_MDTH = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = alpf_pkg::MUL_DV;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MDV;
			end
			S_MDV: begin
				cmd.mul_sel = alpf_pkg::MUL_DV;
				// Clamped and settled items need no arithmetic beyond the checks.
				state_d = status.short_path ? S_FIN : S_MV2;
			end
			S_MV2: begin
				cmd.mul_sel = alpf_pkg::MUL_V2;
				cmd.cap_dv  = 1'b1;
				state_d     = S_MBR;
			end
			S_MBR: begin
				cmd.mul_sel = alpf_pkg::MUL_BR;
				cmd.cap_v2  = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_VEL;
			end
			S_VEL: begin
				cmd.vel = 1'b1;
				state_d = S_MDTH;
			end
			S_MDTH: begin
				cmd.mul_sel = alpf_pkg::MUL_DTH;
				state_d     = S_FIN;
			end
			S_FIN: begin
				// The position step product must hold while the result waits.
				cmd.mul_sel = alpf_pkg::MUL_DTH;
				if (status.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ALPF_ASSERT_NEXT(a_accept_to_prep, clk, arst_n, in_valid && in_ready, state_q == S_PREP, "accepted item did not enter the check state")
	`ALPF_ASSERT_NEXT(a_short_to_fin, clk, arst_n, (state_q == S_MDV) && status.short_path, state_q == S_FIN, "clamped or settled item took the long path")
	`ALPF_ASSERT_NEXT(a_long_to_mul, clk, arst_n, (state_q == S_MDV) && !status.short_path, state_q == S_MV2, "moving item skipped the multiply sequence")

endmodule

// ===== rtl/core/alpf_dp.sv =====
// Datapath: configuration registers, channel state, shared multiplier and result register.
module alpf_dp #(
	parameter int FRAC_BITS = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [alpf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [alpf_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [alpf_pkg::DATA_W-1:0]     in_target,
	input  alpf_pkg::cmd_t                         cmd,
	output alpf_pkg::status_t                      status,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [alpf_pkg::DATA_W-1:0]     out_position,
	output logic signed [alpf_pkg::DATA_W-1:0]     out_velocity,
	output logic                                   out_clamped,
	output logic                                   out_settled,
	output logic                                   out_unstable
);

	localparam int DW     = alpf_pkg::DATA_W;
	localparam int STEP_W = alpf_pkg::STEP_PROD_W - FRAC_BITS;
	localparam int CMP_W  = (STEP_W > DW) ? STEP_W : DW;
	localparam int OV_W   = (STEP_W > 34) ? STEP_W : 34;
	localparam int PS_W   = CMP_W + 2;

	// Configuration registers.
	logic [alpf_pkg::HALF_W-1:0]          half_q;
	logic signed [alpf_pkg::CENTER_W-1:0] center_q;
	logic [alpf_pkg::LIMIT_W-1:0]         vlim_q;
	logic [alpf_pkg::LIMIT_W-1:0]         accel_q;
	logic [alpf_pkg::LIMIT_W-1:0]         tol_q;
	logic [alpf_pkg::TSTEP_W-1:0]         tstep_q;

	// Channel state.
	logic signed [DW-1:0] cur_pos_q;
	logic signed [DW-1:0] cur_vel_q;

	// Per-item working registers.
	logic signed [DW-1:0]                  tgt_q;
	logic signed [alpf_pkg::ERR_W-1:0]     err_q;
	logic [alpf_pkg::ERR_W-1:0]            aerr_q;
	logic [DW-1:0]                         avel_q;
	logic                                  clamp_q;
	logic                                  settle_q;
	logic signed [alpf_pkg::BOUND_W-1:0]   bound_q;
	logic [alpf_pkg::PROD_W-1:0]           prod_q;
	logic [STEP_W-1:0]                     dvmax_q;
	logic [63:0]                           v2_q;
	logic                                  brake_q;
	logic [alpf_pkg::LIMIT_W-1:0]          head_q;
	logic signed [DW-1:0]                  vel_new_q;

	// Result register.
	logic                 out_valid_q;
	logic signed [DW-1:0] out_pos_q;
	logic signed [DW-1:0] out_vel_q;
	logic                 out_clamped_q;
	logic                 out_settled_q;
	logic                 out_unstable_q;

	// Travel bounds and error checks.
	logic signed [alpf_pkg::BOUND_W-1:0] upper;
	logic signed [alpf_pkg::BOUND_W-1:0] lower;
	logic                                hit_upper;
	logic                                hit_lower;
	logic [alpf_pkg::ERR_W-1:0]          aerr_d;

	assign upper = alpf_pkg::BOUND_W'(center_q) + alpf_pkg::BOUND_W'($signed({1'b0, half_q}));
	assign lower = alpf_pkg::BOUND_W'(center_q) - alpf_pkg::BOUND_W'($signed({1'b0, half_q}));
	assign hit_upper = (tgt_q >= DW'(upper));
	assign hit_lower = (tgt_q <= DW'(lower));
	assign aerr_d = err_q[alpf_pkg::ERR_W-1] ? alpf_pkg::ERR_W'(-err_q)
		: alpf_pkg::ERR_W'(err_q);

	// Shared multiplier operands.
	logic [alpf_pkg::MUL_A_W-1:0] mul_a;
	logic [alpf_pkg::MUL_B_W-1:0] mul_b;
	logic [alpf_pkg::PROD_W-1:0]  prod_d;

	always_comb begin
		case (cmd.mul_sel)
			alpf_pkg::MUL_DV: begin
				mul_a = alpf_pkg::MUL_A_W'(accel_q);
				mul_b = alpf_pkg::MUL_B_W'(tstep_q);
			end
			alpf_pkg::MUL_V2: begin
				mul_a = avel_q;
				mul_b = alpf_pkg::MUL_B_W'(avel_q);
			end
			alpf_pkg::MUL_BR: begin
				mul_a = alpf_pkg::MUL_A_W'(accel_q);
				mul_b = aerr_q;
			end
			alpf_pkg::MUL_DTH: begin
				mul_a = alpf_pkg::abs32(vel_new_q);
				mul_b = alpf_pkg::MUL_B_W'(tstep_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Braking test against 2*a*|e|, head room to the speed limit.
	logic       brake_d;
	logic [alpf_pkg::LIMIT_W-1:0] head_d;

	assign brake_d = ({1'b0, v2_q} >= {prod_q[63:0], 1'b0});
	assign head_d  = (avel_q >= DW'(vlim_q)) ? '0
		: alpf_pkg::LIMIT_W'(DW'(vlim_q) - avel_q);

	// Velocity update.
	logic [DW-1:0]          dv_lim;
	logic [DW-1:0]          dv;
	logic                   vel_up;
	logic signed [DW+1:0]   vel_sum;
	logic signed [DW-1:0]   vel_sat;

	assign dv_lim = brake_q ? avel_q : DW'(head_q);
	assign dv     = (CMP_W'(dvmax_q) < CMP_W'(dv_lim)) ? DW'(dvmax_q) : dv_lim;
	// Braking moves toward zero; otherwise the step follows the error's sign.
	assign vel_up = brake_q ? !(!cur_vel_q[DW-1] && (|cur_vel_q))
		: (!err_q[alpf_pkg::ERR_W-1] && (|err_q));
	assign vel_sum = vel_up ? ((DW+2)'(cur_vel_q) + (DW+2)'(dv))
		: ((DW+2)'(cur_vel_q) - (DW+2)'(dv));

	always_comb begin
		if (vel_sum > (DW+2)'(32'sh7FFFFFFF)) begin
			vel_sat = 32'sh7FFFFFFF;
		end else if (vel_sum < (DW+2)'(32'sh80000000)) begin
			vel_sat = 32'sh80000000;
		end else begin
			vel_sat = DW'(vel_sum);
		end
	end

	// Position update with the overshoot check.
	logic [STEP_W-1:0]    dth_mag;
	logic [33:0]          ov_lim;
	logic                 overshoot;
	logic signed [PS_W-1:0] pos_sum;
	logic signed [DW-1:0] pos_sat;

	assign dth_mag   = prod_q[alpf_pkg::STEP_PROD_W-1:FRAC_BITS];
	assign ov_lim    = {1'b0, aerr_q} + {2'b0, tol_q, 1'b0};
	assign overshoot = (OV_W'(dth_mag) > OV_W'(ov_lim));
	assign pos_sum   = vel_new_q[DW-1] ? (PS_W'(cur_pos_q) - PS_W'(dth_mag))
		: (PS_W'(cur_pos_q) + PS_W'(dth_mag));

	always_comb begin
		if (pos_sum > PS_W'(32'sh7FFFFFFF)) begin
			pos_sat = 32'sh7FFFFFFF;
		end else if (pos_sum < PS_W'(32'sh80000000)) begin
			pos_sat = 32'sh80000000;
		end else begin
			pos_sat = DW'(pos_sum);
		end
	end

	// Final result of the item.
	logic signed [DW-1:0] res_pos;
	logic signed [DW-1:0] res_vel;
	logic                 res_unstable;

	always_comb begin
		res_unstable = 1'b0;
		if (clamp_q) begin
			res_pos = DW'(bound_q);
			res_vel = cur_vel_q;
		end else if (settle_q) begin
			res_pos = cur_pos_q;
			res_vel = '0;
		end else if (overshoot) begin
			res_pos = cur_pos_q;
			res_vel = '0;
			res_unstable = 1'b1;
		end else begin
			res_pos = pos_sat;
			res_vel = vel_new_q;
		end
	end

	// Configuration and channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= '0;
			center_q  <= '0;
			vlim_q    <= '0;
			accel_q   <= '0;
			tol_q     <= '0;
			tstep_q   <= alpf_pkg::TSTEP_RST;
			cur_pos_q <= '0;
			cur_vel_q <= '0;
		end else if (cfg_we) begin
			case (alpf_pkg::cfg_reg_t'(cfg_index))
				alpf_pkg::REG_RANGE_HALF: half_q   <= cfg_data[alpf_pkg::HALF_W-1:0];
				alpf_pkg::REG_CENTER:     center_q <= $signed(cfg_data[alpf_pkg::CENTER_W-1:0]);
				alpf_pkg::REG_VEL_LIMIT:  vlim_q   <= cfg_data[alpf_pkg::LIMIT_W-1:0];
				alpf_pkg::REG_ACC_LIMIT:  accel_q  <= cfg_data[alpf_pkg::LIMIT_W-1:0];
				alpf_pkg::REG_TOLERANCE:  tol_q    <= cfg_data[alpf_pkg::LIMIT_W-1:0];
				alpf_pkg::REG_TIME_STEP:  tstep_q  <= cfg_data[alpf_pkg::TSTEP_W-1:0];
				alpf_pkg::REG_START_POS: begin
					cur_pos_q <= DW'($signed(cfg_data[alpf_pkg::CENTER_W-1:0]));
				end
				alpf_pkg::REG_START_VEL: begin
					cur_vel_q <= $signed(cfg_data);
				end
				default: begin
				end
			endcase
		end else if (cmd.fin) begin
			cur_pos_q <= res_pos;
			cur_vel_q <= res_vel;
		end
	end

	// Working registers; payload only.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.load) begin
			tgt_q <= in_target;
			err_q <= alpf_pkg::ERR_W'(in_target) - alpf_pkg::ERR_W'(cur_pos_q);
		end
		if (cmd.prep) begin
			clamp_q  <= hit_upper || hit_lower;
			bound_q  <= hit_upper ? upper : lower;
			aerr_q   <= aerr_d;
			settle_q <= !(hit_upper || hit_lower)
				&& (aerr_d < alpf_pkg::ERR_W'(tol_q));
			avel_q   <= alpf_pkg::abs32(cur_vel_q);
		end
		if (cmd.cap_dv) begin
			dvmax_q <= prod_q[alpf_pkg::STEP_PROD_W-1:FRAC_BITS];
		end
		if (cmd.cap_v2) begin
			v2_q <= prod_q[63:0];
		end
		if (cmd.cmp) begin
			brake_q <= brake_d;
			head_q  <= head_d;
		end
		if (cmd.vel) begin
			vel_new_q <= vel_sat;
		end
		if (cmd.fin) begin
			out_pos_q      <= res_pos;
			out_vel_q      <= res_vel;
			out_clamped_q  <= clamp_q;
			out_settled_q  <= settle_q;
			out_unstable_q <= res_unstable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.short_path = clamp_q || settle_q;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_position = out_pos_q;
	assign out_velocity = out_vel_q;
	assign out_clamped  = out_clamped_q;
	assign out_settled  = out_settled_q;
	assign out_unstable = out_unstable_q;

endmodule

// ===== rtl/core/accel_limited_position_follower.sv =====
// Top level of the acceleration-limited position follower for one channel.
//
//   channel     dir  handshake          payload
//   target_ch   in   valid/ready        target_position
//   result_ch   out  valid/ready        position, velocity, clamped, settled, unstable
//   cfg         in   cfg_we             cfg_index, cfg_data
//
// A moving item passes the check, multiply, compare and velocity states to the result
// register; a clamped or settled item goes from the checks to the result state.
// The four multiplies share one 32x33 multiplier, one multiply at a time.
// A new item is taken only after the previous one has reached the result register.
// Reset clears the configuration to its defaults and the position and velocity to zero.
// A stalled result holds the last step until result_ch.ready is seen.
module accel_limited_position_follower #(
	parameter int FRAC_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [alpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [alpf_pkg::CFG_DATA_W-1:0]  cfg_data,
	alpf_in_if.sink                          target_ch,
	alpf_out_if.source                       result_ch
);

	alpf_pkg::cmd_t    cmd;
	alpf_pkg::status_t status;

	alpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (target_ch.valid),
		.in_ready (target_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	alpf_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_target    (target_ch.target_position),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (result_ch.valid),
		.out_ready    (result_ch.ready),
		.out_position (result_ch.position),
		.out_velocity (result_ch.velocity),
		.out_clamped  (result_ch.clamped),
		.out_settled  (result_ch.settled),
		.out_unstable (result_ch.unstable)
	);

endmodule

// ===== tb/sv/accel_limited_position_follower_test.sv =====
// Self-checking testbench for the acceleration-limited position follower.
`timescale 1ns / 100ps

module accel_limited_position_follower_test;

	localparam int FRAC_BITS      = 20;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int PHASES         = 7;
	localparam int ITEMS_PER_PHASE = 268;
	localparam int POS_SPAN       = 6588397;
	localparam int PLAN_LEN       = 49;

	typedef struct {
		logic signed [alpf_pkg::DATA_W-1:0] position;
		logic signed [alpf_pkg::DATA_W-1:0] velocity;
		logic                               clamped;
		logic                               settled;
		logic                               unstable;
	} step_result_t;

	typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_t;

	// want_flags holds clamped, settled and unstable, in that order.
	typedef struct {
		row_kind_t                          kind;
		alpf_pkg::cfg_reg_t                 reg_idx;
		logic [alpf_pkg::CFG_DATA_W-1:0]    value;
		bit                                 typed;
		logic signed [alpf_pkg::DATA_W-1:0] want_pos;
		logic signed [alpf_pkg::DATA_W-1:0] want_vel;
		logic [2:0]                         want_flags;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [alpf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [alpf_pkg::CFG_DATA_W-1:0] cfg_data;

	alpf_in_if  target_ch();
	alpf_out_if result_ch();

	accel_limited_position_follower #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.target_ch (target_ch),
		.result_ch (result_ch)
	);

	always #2 clk = ~clk;

	// Mirror of the block's registers and motion state.
	logic [alpf_pkg::HALF_W-1:0]          half_width;
	logic signed [alpf_pkg::CENTER_W-1:0] center;
	logic [alpf_pkg::LIMIT_W-1:0]         speed_cap;
	logic [alpf_pkg::LIMIT_W-1:0]         accel_cap;
	logic [alpf_pkg::LIMIT_W-1:0]         tolerance;
	logic [alpf_pkg::TSTEP_W-1:0]         tstep;
	logic signed [alpf_pkg::DATA_W-1:0]   cur_pos;
	logic signed [alpf_pkg::DATA_W-1:0]   cur_vel;

	step_result_t pending_steps [$];
	step_result_t no_want;
	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int results_checked;
	int items_sent;
	int clamp_count, settle_count, cancel_count;
	int settings_count;
	longint cycle_count;

	directed_row_t plan [PLAN_LEN] = '{
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 32'h0000_0000, 1'b1, 0, 0, 3'b100},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 32'hFFFF_FFFF, 1'b1, 0, 0, 3'b100},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 32'h7FFF_FFFF, 1'b1, 0, 0, 3'b100},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 32'h8000_0000, 1'b1, 0, 0, 3'b100},
		'{ROW_WRITE, alpf_pkg::REG_RANGE_HALF, 6588397,       1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_VEL_LIMIT,  32'h7FFF_FFFF, 1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_ACC_LIMIT,  32'h7FFF_FFFF, 1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_TIME_STEP,  32'h0010_0000, 1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 6588397,       1'b1, 6588397, 0, 3'b100},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, -6588397,      1'b1, -6588397, 0, 3'b100},
		// Full speed in one step overshoots, so the move is cancelled.
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 6588396,       1'b1, -6588397, 0, 3'b001},
		'{ROW_WRITE, alpf_pkg::REG_TOLERANCE,  100,           1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, -6588347,      1'b1, -6588397, 0, 3'b010},
		'{ROW_WRITE, alpf_pkg::REG_START_VEL,  32'h8000_0000, 1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 0,             1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_TIME_STEP,  1,             1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_START_POS,  6588397,       1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_START_VEL,  32'h7FFF_FFFF, 1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 0,             1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_TIME_STEP,  1048,          1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_ACC_LIMIT,  1048576000,    1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_VEL_LIMIT,  52428800,      1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_TOLERANCE,  2000,          1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_START_VEL,  0,             1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_START_POS,  -6588397,      1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 3000000,       1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, -3000000,      1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, -3000000,      1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_CENTER,     -6588397,      1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 0,             1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_CENTER,     6588397,       1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_RANGE_HALF, 0,             1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 6588397,       1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_ACC_LIMIT,  0,             1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_RANGE_HALF, 6588397,       1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_CENTER,     0,             1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 100000,        1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_VEL_LIMIT,  0,             1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_ACC_LIMIT,  1048576000,    1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, -100000,       1'b0, 0, 0, 3'b000},
		'{ROW_WRITE, alpf_pkg::REG_TOLERANCE,  32'h7FFF_FFFF, 1'b0, 0, 0, 3'b000},
		'{ROW_ITEM,  alpf_pkg::REG_RANGE_HALF, 5000000,       1'b0, 0, 0, 3'b000}
	};

	function automatic longint magnitude(longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic longint sat_word(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// One control step toward the target; updates the mirrored state.
	function automatic step_result_t follow_target(logic signed [alpf_pkg::DATA_W-1:0] tgt);
		longint upper, lower, pos, vel, err, aerr, tol, avel, dvmax, v2, dv, head, dth;
		logic [67:0] brake_dist;
		step_result_t r;
		upper = longint'(center) + longint'(half_width);
		lower = longint'(center) - longint'(half_width);
		pos = cur_pos;
		vel = cur_vel;
		r.clamped = 1'b0;
		r.settled = 1'b0;
		r.unstable = 1'b0;
		if (longint'(tgt) >= upper) begin
			pos = sat_word(upper);
			r.clamped = 1'b1;
		end else if (longint'(tgt) <= lower) begin
			pos = sat_word(lower);
			r.clamped = 1'b1;
		end else begin
			err = longint'(tgt) - pos;
			aerr = magnitude(err);
			tol = longint'(tolerance);
			if (aerr < tol) begin
				vel = 0;
				r.settled = 1'b1;
			end else begin
				avel = magnitude(vel);
				dvmax = (longint'(accel_cap) * longint'(tstep)) >> FRAC_BITS;
				v2 = avel * avel;
				brake_dist = (68'(accel_cap) * 68'(aerr)) << 1;
				// Brake once the stopping distance covers the error.
				if (68'(v2) >= brake_dist) begin
					dv = (dvmax < avel) ? dvmax : avel;
					vel = (vel > 0) ? vel - dv : vel + dv;
				end else begin
					head = longint'(speed_cap) - avel;
					if (head < 0)
						head = 0;
					dv = (dvmax < head) ? dvmax : head;
					vel = (err > 0) ? vel + dv : vel - dv;
				end
				vel = sat_word(vel);
				dth = (magnitude(vel) * longint'(tstep)) >> FRAC_BITS;
				if (vel < 0)
					dth = -dth;
				if (magnitude(dth) > aerr + 2 * tol) begin
					dth = 0;
					vel = 0;
					r.unstable = 1'b1;
				end
				pos = sat_word(pos + dth);
			end
		end
		cur_pos = 32'(pos);
		cur_vel = 32'(vel);
		r.position = 32'(pos);
		r.velocity = 32'(vel);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
			$realtime, what, results_checked, got, want);
		mismatch_count++;
	endtask

	// Called at a falling edge; leaves the write enable high for a following write.
	task automatic write_reg(alpf_pkg::cfg_reg_t idx, logic [alpf_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			alpf_pkg::REG_RANGE_HALF: half_width = data[alpf_pkg::HALF_W-1:0];
			alpf_pkg::REG_CENTER:     center = data[alpf_pkg::CENTER_W-1:0];
			alpf_pkg::REG_VEL_LIMIT:  speed_cap = data[alpf_pkg::LIMIT_W-1:0];
			alpf_pkg::REG_ACC_LIMIT:  accel_cap = data[alpf_pkg::LIMIT_W-1:0];
			alpf_pkg::REG_TOLERANCE:  tolerance = data[alpf_pkg::LIMIT_W-1:0];
			alpf_pkg::REG_TIME_STEP:  tstep = data[alpf_pkg::TSTEP_W-1:0];
			alpf_pkg::REG_START_POS:  cur_pos = {
				{(alpf_pkg::DATA_W-alpf_pkg::CENTER_W){data[alpf_pkg::CENTER_W-1]}},
				data[alpf_pkg::CENTER_W-1:0]};
			alpf_pkg::REG_START_VEL:  cur_vel = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Drains the block before registers change; the pause covers a moving step.
	task automatic wait_idle();
		target_ch.valid <= 1'b0;
		while (pending_steps.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		settings_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_target(logic signed [alpf_pkg::DATA_W-1:0] t, bit typed,
		step_result_t typed_want);
		step_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			target_ch.valid <= 1'b0;
			@(negedge clk);
		end
		target_ch.valid <= 1'b1;
		target_ch.target_position <= t;
		@(posedge clk);
		while (!target_ch.ready)
			@(posedge clk);
		predicted = follow_target(t);
		if (typed)
			predicted = typed_want;
		pending_steps = {pending_steps, predicted};
		items_sent++;
		clamp_count += predicted.clamped;
		settle_count += predicted.settled;
		cancel_count += predicted.unstable;
		@(negedge clk);
	endtask

	task automatic program_profile(int phase);
		logic [alpf_pkg::CFG_DATA_W-1:0] hw, ctr, vl, al, tl, ts, sp, sv;
		hw = $urandom_range(500000, POS_SPAN);
		ctr = int'($urandom_range(0, 2 * POS_SPAN)) - POS_SPAN;
		vl = $urandom_range(0, 400 << 20);
		al = $urandom_range(1 << 16, 32'h7FFF_FFFF) >> $urandom_range(0, 12);
		tl = $urandom_range(0, 200000);
		ts = $urandom_range(200, 20000);
		sp = int'($urandom_range(0, 2 * POS_SPAN)) - POS_SPAN;
		sv = $urandom_range(0, vl);
		if ($urandom_range(1))
			sv = -sv;
		case (phase)
			1: begin
				hw = POS_SPAN;
				ctr = -POS_SPAN;
				vl = 32'h7FFF_FFFF;
				al = 32'h7FFF_FFFF;
				tl = 0;
				ts = 32'h0010_0000;
				sp = -POS_SPAN;
				sv = 0;
			end
			3: begin
				hw = POS_SPAN;
				ctr = POS_SPAN;
				vl = 32'h7FFF_FFFF;
				al = 32'h7FFF_FFFF;
				tl = 0;
				ts = 1;
				sp = POS_SPAN;
				sv = 32'h8000_0000;
			end
			4: tl = 0;
			6: begin
				// No acceleration: velocity only holds or gets cancelled.
				hw = $urandom_range(0, 1000) << $urandom_range(0, 13);
				al = 0;
				tl = $urandom_range(0, 1 << 20);
				sv = $urandom;
			end
			default: ;
		endcase
		wait_idle();
		write_reg(alpf_pkg::REG_RANGE_HALF, hw);
		write_reg(alpf_pkg::REG_CENTER, ctr);
		write_reg(alpf_pkg::REG_VEL_LIMIT, vl);
		write_reg(alpf_pkg::REG_ACC_LIMIT, al);
		write_reg(alpf_pkg::REG_TOLERANCE, tl);
		write_reg(alpf_pkg::REG_TIME_STEP, ts);
		write_reg(alpf_pkg::REG_START_POS, sp);
		write_reg(alpf_pkg::REG_START_VEL, sv);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		step_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_steps.size() == 0) begin
				report_mismatch("unexpected result, position", result_ch.position, 0);
			end else begin
				want = pending_steps.pop_front();
				if (result_ch.position !== want.position)
					report_mismatch("position", result_ch.position, want.position);
				if (result_ch.velocity !== want.velocity)
					report_mismatch("velocity", result_ch.velocity, want.velocity);
				if (result_ch.clamped !== want.clamped)
					report_mismatch("clamped", result_ch.clamped, want.clamped);
				if (result_ch.settled !== want.settled)
					report_mismatch("settled", result_ch.settled, want.settled);
				if (result_ch.unstable !== want.unstable)
					report_mismatch("unstable", result_ch.unstable, want.unstable);
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_steps.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic signed [alpf_pkg::DATA_W-1:0] goal, tgt;
		longint lo_bound, span, near;
		int hold_left;
		bit writing;
		step_result_t row_want;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		target_ch.valid = 1'b0;
		target_ch.target_position = '0;
		result_ch.ready = 1'b0;
		cycle_count = 0;
		half_width = '0;
		center = '0;
		speed_cap = '0;
		accel_cap = '0;
		tolerance = '0;
		tstep = alpf_pkg::TSTEP_RST;
		cur_pos = '0;
		cur_vel = '0;
		no_want = '{0, 0, 1'b0, 1'b0, 1'b0};
		mismatch_count = 0;
		results_checked = 0;
		items_sent = 0;
		clamp_count = 0;
		settle_count = 0;
		cancel_count = 0;
		settings_count = 1;
		send_idle_pct = 16;
		recv_idle_pct = 54;
		writing = 1'b0;
		hold_left = 0;
		goal = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!writing)
					wait_idle();
				writing = 1'b1;
				write_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				if (writing)
					cfg_we <= 1'b0;
				writing = 1'b0;
				row_want = '{plan[i].want_pos, plan[i].want_vel, plan[i].want_flags[2],
					plan[i].want_flags[1], plan[i].want_flags[0]};
				send_target(plan[i].value, plan[i].typed, row_want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			program_profile(phase);
			// Idling: sender-light first, then receiver-light, then none.
			send_idle_pct = (phase < 2) ? 16 : (phase < 4) ? 54 : 0;
			recv_idle_pct = (phase < 2) ? 54 : (phase < 4) ? 16 : 0;
			hold_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				lo_bound = longint'(center) - longint'(half_width);
				span = 2 * longint'(half_width);
				// Mostly hold a goal for a while so moves run to completion.
				if (hold_left == 0) begin
					hold_left = $urandom_range(1, 60);
					case ($urandom_range(0, 9))
						0: goal = $urandom;
						1: goal = $urandom_range(1) ? 32'(lo_bound) : 32'(lo_bound + span);
						2: begin
							near = (tolerance > 1000000) ? 1000000 : longint'(tolerance);
							goal = 32'(longint'(cur_pos) + longint'($urandom_range(0,
								32'(2 * near + 2))) - near - 1);
						end
						default: goal = 32'(lo_bound + longint'($urandom_range(0, 32'(span))));
					endcase
				end
				hold_left--;
				tgt = ($urandom_range(0, 19) == 0) ? $urandom : goal;
				send_target(tgt, 1'b0, no_want);
			end
		end

		target_ch.valid <= 1'b0;
		while (pending_steps.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d target items over %0d register settings, %0d results checked.",
			items_sent, settings_count, results_checked);
		$display("Steps: %0d clamped, %0d settled, %0d cancelled, %0d moving; %0d mismatches.",
			clamp_count, settle_count, cancel_count,
			items_sent - clamp_count - settle_count - cancel_count, mismatch_count);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/alpf_pkg.sv
rtl/core/alpf_ifs.sv
rtl/core/alpf_ctrl.sv
rtl/core/alpf_dp.sv
rtl/core/accel_limited_position_follower.sv
tb/sv/accel_limited_position_follower_test.sv
